// ===== hdl/ngqrng_pkg.sv =====
// ----------------------------------------------------------------------------
// ngqrng_pkg
// Shared widths, command struct and the elaboration-time functions that build
// the base-2 Niederreiter direction-word ROM.
// ----------------------------------------------------------------------------
package ngqrng_pkg;

  localparam int DIM_W         = 3;
  localparam int GRAY_W        = 32;
  localparam int VALUE_W       = 63;
  localparam int WORDS_PER_DIM = 32;
  localparam int GROUPS        = 4;
  localparam int GROUP_SZ      = WORDS_PER_DIM / GROUPS;
  // Dimensions reachable through a 3-bit dimension field.
  localparam int MAX_DIMS      = 1 << DIM_W;
  localparam int WORK_LEN      = 128;

  typedef logic [WORDS_PER_DIM-1:0][VALUE_W-1:0] dir_row_t;
  typedef logic [GROUPS-1:0][VALUE_W-1:0]        part_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // request accepted: read state and ROM row
    logic commit;  // write back state and load the output register
  } cmd_t;

  // Degree of a GF(2) polynomial, -1 for zero.
  function automatic int poly_deg(logic [31:0] a);
    int d;
    d = -1;
    for (int i = 0; i < 32; i++) begin
      if (a[i]) d = i;
    end
    return d;
  endfunction

  // Remainder of a modulo q over GF(2).
  function automatic logic [31:0] poly_mod(logic [31:0] a, logic [31:0] q);
    int          dq;
    int          da;
    logic [31:0] r;
    r  = a;
    dq = poly_deg(q);
    for (int s = 0; s < 32; s++) begin
      da = poly_deg(r);
      if (r != '0 && dq >= 0 && da >= dq) r = r ^ (q << (da - dq));
    end
    return r;
  endfunction

  // n-th irreducible polynomial in increasing numeric order, starting at x.
  function automatic logic [31:0] nth_poly(int n);
    logic [31:0] polys [MAX_DIMS];
    logic [31:0] c;
    logic        irr;
    logic        found;
    for (int p = 0; p < MAX_DIMS; p++) polys[p] = '0;
    polys[0] = 32'h2;
    for (int p = 1; p < MAX_DIMS; p++) begin
      c     = polys[p-1] + 32'd1;
      found = 1'b0;
      for (int tries = 0; tries < 256; tries++) begin
        if (!found) begin
          irr = 1'b1;
          for (int i = 0; i < p; i++) begin
            if (poly_mod(c, polys[i]) == '0) irr = 1'b0;
          end
          if (irr) found = 1'b1;
          else     c = c + 32'd1;
        end
      end
      polys[p] = c;
    end
    return polys[n];
  endfunction

  // Direction words 0..31 of one dimension.
  function automatic dir_row_t dir_row(int dim);
    logic [31:0] poly;
    int          e;
    int          vlen;
    int          m;
    int          m1;
    int          u;
    logic        pc [WORK_LEN];
    logic        b  [WORK_LEN];
    logic        t  [WORK_LEN];
    logic        v  [WORK_LEN];
    logic        acc;
    dir_row_t    row;
    poly = nth_poly(dim);
    e    = poly_deg(poly);
    vlen = VALUE_W + e - 1;
    m    = 0;
    m1   = 0;
    u    = e;
    row  = '0;
    for (int k = 0; k < WORK_LEN; k++) begin
      pc[k] = 1'b0;
      b[k]  = 1'b0;
      t[k]  = 1'b0;
      v[k]  = 1'b0;
    end
    for (int k = 0; k <= e; k++) pc[k] = poly[e-k];
    b[0] = 1'b1;
    for (int j = VALUE_W - 1; j >= 0; j--) begin
      if (u == e) begin
        u  = 0;
        m1 = m;
        t  = b;
        m  = m + e;
        // b = pc * t
        for (int i = 0; i <= m; i++) begin
          acc = 1'b0;
          for (int k = 0; k <= e; k++) begin
            if (i - k >= 0 && i - k <= m1) acc = acc ^ (pc[k] & t[i-k]);
          end
          b[i] = acc;
        end
        // linear recurrence over b
        for (int i = 0; i < vlen; i++) begin
          if (i < m1) begin
            v[i] = 1'b0;
          end else if (i < m) begin
            v[i] = 1'b1;
          end else begin
            acc = 1'b0;
            for (int k = 1; k <= m; k++) acc = acc ^ (v[i-k] & b[k]);
            v[i] = acc;
          end
        end
      end
      for (int i = 0; i < WORDS_PER_DIM; i++) begin
        if (v[i+u]) row[i][j] = 1'b1;
      end
      u++;
    end
    return row;
  endfunction

endpackage

// ===== hdl/ngqrng_ctrl.sv =====
// ----------------------------------------------------------------------------
// ngqrng_ctrl
// Two-state controller: accept a request, then commit it to the state and
// the output register once the output register is free.
// ----------------------------------------------------------------------------
module ngqrng_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ngqrng_pkg::cmd_t  cmd
);
  import ngqrng_pkg::*;

  typedef enum logic {ST_IDLE, ST_COMMIT} state_t;

  state_t state;
  logic   out_free;

  // Output register can take a result this cycle.
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE);
  assign cmd.load   = (state == ST_IDLE) && in_valid;
  assign cmd.commit = (state == ST_COMMIT) && out_free;

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (cmd.commit)      out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/ngqrng_dpath.sv =====
// ----------------------------------------------------------------------------
// ngqrng_dpath
// Per-dimension Gray code and running value, direction ROM, masked XOR
// reduction in two registered steps, and the output register.
// ----------------------------------------------------------------------------
module ngqrng_dpath #(
  parameter int NSTORE = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ngqrng_pkg::cmd_t              cmd,
  input  logic [ngqrng_pkg::DIM_W-1:0]  dimension,
  input  logic [ngqrng_pkg::GRAY_W-1:0] seq_index,
  output logic [ngqrng_pkg::VALUE_W-1:0] point_value
);
  import ngqrng_pkg::*;

  localparam int               DIDX_W   = (NSTORE > 1) ? $clog2(NSTORE) : 1;
  localparam logic [DIM_W:0]   NSTORE_L = (DIM_W + 1)'(NSTORE);

  // Direction ROM, one row per dimension, built at elaboration.
  dir_row_t rom_rows [NSTORE];
  for (genvar d = 0; d < NSTORE; d++) begin : g_rom
    localparam dir_row_t ROW = dir_row(d);
    assign rom_rows[d] = ROW;
  end

  // Per-dimension state
  logic [GRAY_W-1:0]  last_gray     [NSTORE];
  logic [VALUE_W-1:0] running_value [NSTORE];

  // First step registers
  logic               s1_oob;
  logic [DIDX_W-1:0]  s1_idx;
  logic [GRAY_W-1:0]  s1_gray;
  logic [VALUE_W-1:0] s1_value;
  part_t              s1_part;

  logic               dim_ok;
  logic [DIDX_W-1:0]  rd_idx;
  logic [GRAY_W-1:0]  gray;
  logic [GRAY_W-1:0]  diff;
  dir_row_t           row;
  part_t              part_next;
  logic [VALUE_W-1:0] value_next;

  // Gray code and difference against the stored one
  assign dim_ok = ({1'b0, dimension} < NSTORE_L);
  assign rd_idx = dim_ok ? DIDX_W'(dimension) : '0;
  assign gray   = seq_index ^ (seq_index >> 1);
  assign diff   = last_gray[rd_idx] ^ gray;
  assign row    = rom_rows[rd_idx];

  // Masked words folded into GROUPS partial XORs
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < GROUP_SZ; k++) begin
        part_next[g] = part_next[g] ^
                       (row[g*GROUP_SZ+k] & {VALUE_W{diff[g*GROUP_SZ+k]}});
      end
    end
  end

  // Final fold with the running value
  always_comb begin
    value_next = s1_value;
    for (int g = 0; g < GROUPS; g++) value_next = value_next ^ s1_part[g];
  end

  // First step capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s1_oob   <= !dim_ok;
      s1_idx   <= rd_idx;
      s1_gray  <= gray;
      s1_value <= running_value[rd_idx];
      s1_part  <= part_next;
    end
  end

  // State write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTORE; i++) begin
        last_gray[i]     <= '0;
        running_value[i] <= '0;
      end
    end else if (cmd.commit && !s1_oob) begin
      last_gray[s1_idx]     <= s1_gray;
      running_value[s1_idx] <= value_next;
    end
  end

  // Output register; out-of-range dimension reads as zero
  always_ff @(posedge clk) begin
    if (cmd.commit) point_value <= s1_oob ? '0 : value_next;
  end

endmodule

// ===== hdl/niederreiter_gray_code_qrng_core.sv =====
// ----------------------------------------------------------------------------
// niederreiter_gray_code_qrng_core
// Base-2 Niederreiter quasi-random generator with Gray-code stepping.
// ----------------------------------------------------------------------------
// Each request names a dimension and a 32-bit sequence index; the block XORs
// the direction words selected by the change in Gray code into that
// dimension's running value and returns the 63-bit point. A request is handled
// in an accept step and a commit step: the accept step reads the per-dimension
// state and the ROM row and folds the masked words into four partial sums, and
// the commit step finishes the fold, writes the state back and loads the output
// register. A new request is not taken until the previous one has committed; the
// commit waits while the output register holds an untaken result. A dimension
// at or above NDIM returns zero and leaves the state untouched.
// ----------------------------------------------------------------------------
module niederreiter_gray_code_qrng_core #(
  parameter int NDIM = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ngqrng_pkg::DIM_W-1:0]   dimension,
  input  logic [ngqrng_pkg::GRAY_W-1:0]  seq_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ngqrng_pkg::VALUE_W-1:0] point_value
);
  import ngqrng_pkg::*;

  // Only dimensions the 3-bit field can name need storage.
  localparam int NSTORE = (NDIM < MAX_DIMS) ? NDIM : MAX_DIMS;

  cmd_t cmd;

  ngqrng_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ngqrng_dpath #(
    .NSTORE (NSTORE)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .dimension   (dimension),
    .seq_index   (seq_index),
    .point_value (point_value)
  );

  // An accepted request blocks the input for the next cycle.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // A commit always presents a result.
  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not raise out_valid");

  // Load and commit never coincide.
  a_load_commit_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.commit))
    else $error("load and commit in the same cycle");

endmodule
